// ===== src/pip_pkg.sv =====
// point in polygon test package: sizes, coordinate and vertex types, codes
// and the structs that pass between the cells, the edge unit and the top level
// no dependencies
package pip_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int MIN_VERTICES = 3;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int COORD_W      = 16;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int NUM_W        = PROD_W + 1;
   localparam int REL_W        = 2;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [NUM_W-1:0]   num_type;
   typedef logic [CNT_W-1:0]          count_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vertex_type;

   typedef struct packed {
      coord_type left;
      coord_type right;
      coord_type bottom;
      coord_type top;
   } box_type;

   typedef enum logic [REL_W-1:0] {
      REL_OUTSIDE,
      REL_BOUNDARY,
      REL_INSIDE,
      REL_INVALID
   } relation_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic       valid;
      logic       clear;
      vertex_type a;
      vertex_type b;
   } edge_req_type;

   typedef struct packed {
      logic boundary;
      logic parity;
   } edge_sum_type;

endpackage

// ===== src/pip_if.sv =====
// request and response channel interfaces of the point in polygon test
// depends on pip_pkg
interface pip_req_if;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic                      new_polygon;
   logic signed [15:0]        point_x;
   logic signed [15:0]        point_y;

   modport source (output valid, kind, new_polygon, point_x, point_y, input ready);
   modport sink (input valid, kind, new_polygon, point_x, point_y, output ready);
endinterface

interface pip_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [pip_pkg::REL_W-1:0] relation;

   modport source (output valid, relation, input ready);
   modport sink (input valid, relation, output ready);
endinterface

// ===== src/point_in_polygon_test.sv =====
// point in polygon test top level: ring of vertex cells, edge unit and control
// vertex transaction: one per cycle while no query is in progress, no response
// query refused as invalid or outside the bounding box: response valid in the cycle after accept
// other queries: the ring rotates once past the edge unit through SCAN, DRAIN and FINISH,
// response valid after FINISH, next transaction accepted from that cycle on
// synchronous reset empties the polygon and clears overflow; stored vertices keep garbage
module point_in_polygon_test (
   input  logic      clock,
   input  logic      reset,
   pip_req_if.sink   req_chan,
   pip_rsp_if.source rsp_chan
);

   pip_pkg::state_type    state_ff, state_in;
   pip_pkg::count_type    count_ff, count_in;
   pip_pkg::count_type    step_ff, step_in;
   pip_pkg::count_type    eff_count;
   logic                  overflow_ff, overflow_in;
   logic                  drain_ff, drain_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pip_pkg::relation_type rsp_relation_ff, rsp_relation_in;
   pip_pkg::box_type      box_ff, box_in;
   pip_pkg::vertex_type   query_ff, query_in;
   pip_pkg::vertex_type   prev_ff, prev_in;
   pip_pkg::vertex_type   first_ff, first_in;
   pip_pkg::vertex_type   req_point;
   pip_pkg::vertex_type   head;
   pip_pkg::vertex_type   cell_point [pip_pkg::MAX_VERTICES];
   pip_pkg::edge_req_type edge_req;
   pip_pkg::edge_sum_type edge_sum;

   logic                  out_free;
   logic                  req_ready;
   logic                  accept;
   logic                  vertex_accept;
   logic                  query_accept;
   logic                  query_invalid;
   logic                  query_outside;
   logic                  load_hit;
   logic                  rotate;
   logic                  rsp_set;
   pip_pkg::relation_type rsp_code;

   assign req_point.x   = req_chan.point_x;
   assign req_point.y   = req_chan.point_y;
   assign head          = cell_point[0];
   assign out_free      = !rsp_valid_ff || rsp_chan.ready;
   assign accept        = req_chan.valid && req_ready;
   assign vertex_accept = accept && (req_chan.kind == pip_pkg::KIND_VERTEX);
   assign query_accept  = accept && (req_chan.kind == pip_pkg::KIND_QUERY);
   assign eff_count     = req_chan.new_polygon ? '0 : count_ff;
   assign load_hit      = vertex_accept &&
                          (eff_count != pip_pkg::count_type'(pip_pkg::MAX_VERTICES));

   assign query_invalid = overflow_ff ||
                          (count_ff < pip_pkg::count_type'(pip_pkg::MIN_VERTICES));
   assign query_outside = (req_point.x < box_ff.left) || (req_point.x > box_ff.right) ||
                          (req_point.y < box_ff.bottom) || (req_point.y > box_ff.top);

   // vertex ring
   for (genvar k = 0; k < pip_pkg::MAX_VERTICES; k++) begin : g_cell
      pip_pkg::cell_ctrl_type ctrl;
      assign ctrl.load  = load_hit &&
                          (eff_count[pip_pkg::IDX_W-1:0] == pip_pkg::IDX_W'(k));
      assign ctrl.shift = rotate;
      pip_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .load_point (req_point),
         .next_point (cell_point[(k + 1) % pip_pkg::MAX_VERTICES]),
         .point      (cell_point[k])
      );
   end

   pip_edge u_edge (
      .clock    (clock),
      .reset    (reset),
      .edge_req (edge_req),
      .query    (query_ff),
      .sum      (edge_sum)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pip_pkg::ST_IDLE: begin
            if (query_accept && !query_invalid && !query_outside) begin
               state_in = pip_pkg::ST_SCAN;
            end
         end
         pip_pkg::ST_SCAN: begin
            if (step_ff == pip_pkg::count_type'(pip_pkg::MAX_VERTICES)) begin
               state_in = pip_pkg::ST_DRAIN;
            end
         end
         pip_pkg::ST_DRAIN: begin
            if (drain_ff) begin
               state_in = pip_pkg::ST_FINISH;
            end
         end
         pip_pkg::ST_FINISH: begin
            state_in = pip_pkg::ST_IDLE;
         end
         default: begin
            state_in = pip_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      rotate         = 1'b0;
      rsp_set        = 1'b0;
      rsp_code       = pip_pkg::REL_OUTSIDE;
      edge_req.valid = 1'b0;
      edge_req.clear = 1'b0;
      edge_req.a     = prev_ff;
      edge_req.b     = (step_ff == count_ff) ? first_ff : head;
      case (state_ff)
         pip_pkg::ST_IDLE: begin
            req_ready = (req_chan.kind == pip_pkg::KIND_VERTEX) || out_free;
            if (query_accept) begin
               if (query_invalid) begin
                  rsp_set  = 1'b1;
                  rsp_code = pip_pkg::REL_INVALID;
               end else if (query_outside) begin
                  rsp_set  = 1'b1;
                  rsp_code = pip_pkg::REL_OUTSIDE;
               end else begin
                  edge_req.clear = 1'b1;
               end
            end
         end
         pip_pkg::ST_SCAN: begin
            rotate         = (step_ff != pip_pkg::count_type'(pip_pkg::MAX_VERTICES));
            edge_req.valid = (step_ff != '0) && (step_ff <= count_ff);
         end
         pip_pkg::ST_DRAIN: begin
         end
         pip_pkg::ST_FINISH: begin
            rsp_set = 1'b1;
            if (edge_sum.boundary) begin
               rsp_code = pip_pkg::REL_BOUNDARY;
            end else if (edge_sum.parity) begin
               rsp_code = pip_pkg::REL_INSIDE;
            end else begin
               rsp_code = pip_pkg::REL_OUTSIDE;
            end
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      count_in        = count_ff;
      overflow_in     = overflow_ff;
      box_in          = box_ff;
      query_in        = query_ff;
      prev_in         = prev_ff;
      first_in        = first_ff;
      step_in         = '0;
      drain_in        = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_relation_in = rsp_relation_ff;
      if (vertex_accept) begin
         if (req_chan.new_polygon) begin
            overflow_in = 1'b0;
         end
         if (load_hit) begin
            count_in = eff_count + pip_pkg::count_type'(1);
            if (eff_count == '0) begin
               box_in.left   = req_point.x;
               box_in.right  = req_point.x;
               box_in.bottom = req_point.y;
               box_in.top    = req_point.y;
            end else begin
               if (req_point.x < box_ff.left)   box_in.left   = req_point.x;
               if (req_point.x > box_ff.right)  box_in.right  = req_point.x;
               if (req_point.y < box_ff.bottom) box_in.bottom = req_point.y;
               if (req_point.y > box_ff.top)    box_in.top    = req_point.y;
            end
         end else begin
            count_in    = eff_count;
            overflow_in = 1'b1;
         end
      end
      if (query_accept) begin
         query_in = req_point;
      end
      if (state_ff == pip_pkg::ST_SCAN) begin
         step_in = step_ff + pip_pkg::count_type'(1);
         prev_in = head;
         if (step_ff == '0) begin
            first_in = head;
         end
      end
      if (state_ff == pip_pkg::ST_DRAIN) begin
         drain_in = 1'b1;
      end
      if (rsp_set) begin
         rsp_valid_in    = 1'b1;
         rsp_relation_in = rsp_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pip_pkg::ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         step_ff      <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         step_ff      <= step_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_relation_ff <= rsp_relation_in;
      box_ff          <= box_in;
      query_ff        <= query_in;
      prev_ff         <= prev_in;
      first_ff        <= first_in;
   end

   assign req_chan.ready    = req_ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.relation = rsp_relation_ff;

   // assertions
   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pip_pkg::ST_FINISH) |-> out_free)
      else $error("response slot still full at end of scan");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pip_pkg::count_type'(pip_pkg::MAX_VERTICES))
      else $error("vertex count beyond capacity");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (count_ff == pip_pkg::count_type'(pip_pkg::MAX_VERTICES)))
      else $error("overflow flagged with store not full");

   a_scan_step: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pip_pkg::ST_SCAN) &&
       (step_ff != pip_pkg::count_type'(pip_pkg::MAX_VERTICES)))
      |=> ((state_ff == pip_pkg::ST_SCAN) &&
           (step_ff == $past(step_ff) + pip_pkg::count_type'(1))))
      else $error("scan step did not advance");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pip_pkg::ST_IDLE) |-> !rotate || !load_hit)
      else $error("vertex load during ring rotation");

endmodule

// ===== src/pip_cell.sv =====
// one cell of the vertex ring: holds one polygon vertex, loads it from the
// request or takes its neighbor's vertex when the ring rotates; uses pip_pkg
module pip_cell (
   input  logic                   clock,
   input  pip_pkg::cell_ctrl_type ctrl,
   input  pip_pkg::vertex_type    load_point,
   input  pip_pkg::vertex_type    next_point,
   output pip_pkg::vertex_type    point
);

   pip_pkg::vertex_type point_ff;
   pip_pkg::vertex_type point_in;

   always_comb begin
      point_in = point_ff;
      if (ctrl.load) begin
         point_in = load_point;
      end else if (ctrl.shift) begin
         point_in = next_point;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
   end

   assign point = point_ff;

endmodule

// ===== src/pip_edge.sv =====
// edge unit: three-stage pipeline that tests one polygon edge per cycle
// against the query point and accumulates boundary contact and ray parity
// uses pip_pkg
module pip_edge (
   input  logic                  clock,
   input  logic                  reset,
   input  pip_pkg::edge_req_type edge_req,
   input  pip_pkg::vertex_type   query,
   output pip_pkg::edge_sum_type sum
);

   typedef struct packed {
      logic              valid;
      logic              skip;
      logic              horiz;
      logic              hb;
      logic              low;
      pip_pkg::diff_type dx1;
      pip_pkg::diff_type den;
      pip_pkg::diff_type dy;
      pip_pkg::diff_type dxe;
   } s1_type;

   typedef struct packed {
      logic              valid;
      logic              skip;
      logic              horiz;
      logic              hb;
      logic              low;
      logic              den_neg;
      pip_pkg::prod_type p1;
      pip_pkg::prod_type p2;
   } s2_type;

   pip_pkg::coord_type x1, y1, x2, y2, px, py;
   pip_pkg::coord_type maxx, minx, maxy, miny;
   pip_pkg::num_type   num;
   logic               right_side;
   s1_type             s1_ff, s1_in;
   s2_type             s2_ff, s2_in;
   pip_pkg::edge_sum_type sum_ff, sum_in;

   // stage one: spans and differences
   always_comb begin
      x1   = edge_req.a.x;
      y1   = edge_req.a.y;
      x2   = edge_req.b.x;
      y2   = edge_req.b.y;
      px   = query.x;
      py   = query.y;
      maxx = (x1 > x2) ? x1 : x2;
      minx = (x1 < x2) ? x1 : x2;
      maxy = (y1 > y2) ? y1 : y2;
      miny = (y1 < y2) ? y1 : y2;
      s1_in.valid = edge_req.valid && !edge_req.clear;
      s1_in.skip  = (px > maxx) || (py > maxy) || (py < miny);
      s1_in.horiz = (y1 == y2);
      s1_in.hb    = (px >= minx) && (px <= maxx);
      s1_in.low   = (py == miny);
      s1_in.dx1   = pip_pkg::diff_type'(x1) - pip_pkg::diff_type'(px);
      s1_in.den   = pip_pkg::diff_type'(y1) - pip_pkg::diff_type'(y2);
      s1_in.dy    = pip_pkg::diff_type'(py) - pip_pkg::diff_type'(y1);
      s1_in.dxe   = pip_pkg::diff_type'(x1) - pip_pkg::diff_type'(x2);
   end

   // stage two: cross products
   always_comb begin
      s2_in.valid   = s1_ff.valid && !edge_req.clear;
      s2_in.skip    = s1_ff.skip;
      s2_in.horiz   = s1_ff.horiz;
      s2_in.hb      = s1_ff.hb;
      s2_in.low     = s1_ff.low;
      s2_in.den_neg = s1_ff.den[pip_pkg::DIFF_W-1];
      s2_in.p1      = s1_ff.dx1 * s1_ff.den;
      s2_in.p2      = s1_ff.dy * s1_ff.dxe;
   end

   // stage three: sign of the crossing offset and accumulation
   always_comb begin
      num        = pip_pkg::num_type'(s2_ff.p1) + pip_pkg::num_type'(s2_ff.p2);
      right_side = (num[pip_pkg::NUM_W-1] == s2_ff.den_neg);
      sum_in     = sum_ff;
      if (edge_req.clear) begin
         sum_in.boundary = 1'b0;
         sum_in.parity   = 1'b0;
      end else if (s2_ff.valid && !s2_ff.skip) begin
         if (s2_ff.horiz) begin
            sum_in.boundary = sum_ff.boundary || s2_ff.hb;
         end else if (num == pip_pkg::num_type'(0)) begin
            sum_in.boundary = 1'b1;
         end else if (right_side && !s2_ff.low) begin
            sum_in.parity = !sum_ff.parity;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         sum_ff      <= '0;
      end else begin
         s1_ff.valid <= s1_in.valid;
         s2_ff.valid <= s2_in.valid;
         sum_ff      <= sum_in;
      end
      s1_ff.skip    <= s1_in.skip;
      s1_ff.horiz   <= s1_in.horiz;
      s1_ff.hb      <= s1_in.hb;
      s1_ff.low     <= s1_in.low;
      s1_ff.dx1     <= s1_in.dx1;
      s1_ff.den     <= s1_in.den;
      s1_ff.dy      <= s1_in.dy;
      s1_ff.dxe     <= s1_in.dxe;
      s2_ff.skip    <= s2_in.skip;
      s2_ff.horiz   <= s2_in.horiz;
      s2_ff.hb      <= s2_in.hb;
      s2_ff.low     <= s2_in.low;
      s2_ff.den_neg <= s2_in.den_neg;
      s2_ff.p1      <= s2_in.p1;
      s2_ff.p2      <= s2_in.p2;
   end

   assign sum = sum_ff;

endmodule

// ===== tb/sv/point_in_polygon_test_tb.sv =====
// self-checking testbench for point_in_polygon_test: loads polygons, sends queries
// and checks every relation against a cycle-free predictor of the vertex store
// depends on pip_pkg, pip_if and the point_in_polygon_test top level
module point_in_polygon_test_tb;

   localparam int TARGET_ITEMS = 1450;
   localparam int RUN_LIMIT    = 10_000_000;

   typedef struct {
      logic               kind;
      logic               new_polygon;
      pip_pkg::coord_type x;
      pip_pkg::coord_type y;
      bit                 hold_until_done;
   } point_item_type;

   logic clock;
   logic reset;

   pip_req_if req_bus ();
   pip_rsp_if rsp_bus ();

   point_in_polygon_test dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   point_item_type        pending_items[$];
   pip_pkg::relation_type expected_relations[$];
   int                    total_items;
   int                    accepted_count;
   int                    mismatch_count;

   // predictor state
   pip_pkg::coord_type poly_x[pip_pkg::MAX_VERTICES];
   pip_pkg::coord_type poly_y[pip_pkg::MAX_VERTICES];
   int                 poly_count;
   pip_pkg::box_type   poly_box;
   bit                 poly_overflow;

   // generator view of the polygon being built
   int shape_x[$];
   int shape_y[$];

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic store_vertex(input pip_pkg::coord_type x, input pip_pkg::coord_type y);
      if (poly_count >= pip_pkg::MAX_VERTICES) begin
         poly_overflow = 1'b1;
      end else begin
         poly_x[poly_count] = x;
         poly_y[poly_count] = y;
         if (poly_count == 0) begin
            poly_box = '{left: x, right: x, bottom: y, top: y};
         end else begin
            if (x < poly_box.left) poly_box.left = x;
            if (x > poly_box.right) poly_box.right = x;
            if (y < poly_box.bottom) poly_box.bottom = y;
            if (y > poly_box.top) poly_box.top = y;
         end
         poly_count++;
      end
   endtask

   function automatic pip_pkg::relation_type classify_point(input pip_pkg::coord_type px,
                                                            input pip_pkg::coord_type py);
      longint x1, y1, x2, y2, maxx, minx, maxy, miny, num, den, qx, qy;
      int     crossings;
      int     i;
      int     j;
      bit     right_side;
      crossings = 0;
      if (poly_overflow || poly_count < pip_pkg::MIN_VERTICES)
         return pip_pkg::REL_INVALID;
      if (px < poly_box.left || px > poly_box.right || py < poly_box.bottom || py > poly_box.top)
         return pip_pkg::REL_OUTSIDE;
      qx = px;
      qy = py;
      for (i = 0; i < poly_count; i++) begin
         j = (i + 1 < poly_count) ? i + 1 : 0;
         x1 = poly_x[i];
         y1 = poly_y[i];
         x2 = poly_x[j];
         y2 = poly_y[j];
         maxx = (x1 > x2) ? x1 : x2;
         minx = (x1 < x2) ? x1 : x2;
         maxy = (y1 > y2) ? y1 : y2;
         miny = (y1 < y2) ? y1 : y2;
         if (qx > maxx || qy > maxy || qy < miny)
            continue;
         // horizontal edge: boundary contact only
         if (maxy == miny) begin
            if (qx >= minx && qx <= maxx)
               return pip_pkg::REL_BOUNDARY;
            continue;
         end
         den = y1 - y2;
         num = (x1 - qx) * den + (qy - y1) * (x1 - x2);
         if (num == 0)
            return pip_pkg::REL_BOUNDARY;
         right_side = ((num > 0) == (den > 0));
         if (!right_side || qy == miny)
            continue;
         crossings++;
      end
      return (crossings % 2 == 1) ? pip_pkg::REL_INSIDE : pip_pkg::REL_OUTSIDE;
   endfunction

   task automatic apply_transaction(input point_item_type item);
      if (item.kind == pip_pkg::KIND_VERTEX) begin
         if (item.new_polygon) begin
            poly_count    = 0;
            poly_overflow = 1'b0;
         end
         store_vertex(item.x, item.y);
      end else begin
         expected_relations.push_back(classify_point(item.x, item.y));
      end
   endtask

   function automatic int pick_between(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int clamp16(input int v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
   endfunction

   function automatic int rand_near(input int c, input int span);
      return clamp16(c + pick_between(-span, span));
   endfunction

   function automatic int gcd_of(input int a, input int b);
      int t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic int idle_pct(input bit receiver_side);
      int phase;
      phase = (total_items == 0) ? 0 : accepted_count * 3 / total_items;
      case (phase)
         0: return receiver_side ? 78 : 23;
         1: return receiver_side ? 23 : 78;
         default: return 0;
      endcase
   endfunction

   task automatic push_item(input logic kind, input logic new_polygon, input int x, input int y,
                            input bit hold);
      point_item_type item;
      item.kind            = kind;
      item.new_polygon     = new_polygon;
      item.x               = pip_pkg::coord_type'(x);
      item.y               = pip_pkg::coord_type'(y);
      item.hold_until_done = hold;
      pending_items.push_back(item);
   endtask

   task automatic build_polygon(input int n, input bit hold, input bit restart);
      int mode, span, cx, cy, x0, x1, y0, y1, k;
      shape_x.delete();
      shape_y.delete();
      mode = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
         0: span = 2;
         1: span = 12;
         2: span = 200;
         default: span = 32767;
      endcase
      if (span == 32767) begin
         cx = 0;
         cy = 0;
      end else begin
         case ($urandom_range(0, 4))
            0: cx = -32768;
            1: cx = 32767;
            default: cx = pick_between(-32768, 32767);
         endcase
         case ($urandom_range(0, 4))
            0: cy = -32768;
            1: cy = 32767;
            default: cy = pick_between(-32768, 32767);
         endcase
      end
      if (mode < 2 && n >= pip_pkg::MIN_VERTICES && n < 40) begin
         x0 = rand_near(cx, span);
         x1 = rand_near(cx, span);
         y0 = rand_near(cy, span);
         y1 = rand_near(cy, span);
         shape_x = '{x0, x1, x1, x0};
         shape_y = '{y0, y0, y1, y1};
         if (mode == 1) begin
            shape_x.reverse();
            shape_y.reverse();
         end
      end else begin
         for (k = 0; k < n; k++) begin
            shape_x.push_back(rand_near(cx, span));
            shape_y.push_back(rand_near(cy, span));
         end
      end
      for (k = 0; k < shape_x.size(); k++)
         push_item(pip_pkg::KIND_VERTEX, (k == 0) && restart, shape_x[k], shape_y[k],
                   hold && (k == 0));
      while (shape_x.size() > pip_pkg::MAX_VERTICES) begin
         void'(shape_x.pop_back());
         void'(shape_y.pop_back());
      end
   endtask

   task automatic add_queries(input int count);
      int m, q, r, i, j, dx, dy, g, k, x, y;
      int left, right, bottom, top;
      m = shape_x.size();
      left   = 32767;
      right  = -32768;
      bottom = 32767;
      top    = -32768;
      for (i = 0; i < m; i++) begin
         if (shape_x[i] < left) left = shape_x[i];
         if (shape_x[i] > right) right = shape_x[i];
         if (shape_y[i] < bottom) bottom = shape_y[i];
         if (shape_y[i] > top) top = shape_y[i];
      end
      for (q = 0; q < count; q++) begin
         r = $urandom_range(0, 99);
         if (m == 0 || r >= 75 && r < 85) begin
            x = pick_between(-32768, 32767);
            y = pick_between(-32768, 32767);
         end else if (r < 30) begin
            x = pick_between(left, right);
            y = pick_between(bottom, top);
         end else if (r < 45) begin
            i = $urandom_range(0, m - 1);
            x = shape_x[i];
            y = shape_y[i];
         end else if (r < 65) begin
            // lattice point on an edge
            i  = $urandom_range(0, m - 1);
            j  = (i + 1) % m;
            dx = shape_x[j] - shape_x[i];
            dy = shape_y[j] - shape_y[i];
            g  = gcd_of((dx < 0) ? -dx : dx, (dy < 0) ? -dy : dy);
            k  = (g == 0) ? 0 : pick_between(0, g);
            x  = shape_x[i] + ((g == 0) ? 0 : dx / g * k);
            y  = shape_y[i] + ((g == 0) ? 0 : dy / g * k);
         end else if (r < 75) begin
            // ray through a vertex
            i = $urandom_range(0, m - 1);
            x = pick_between(left, right);
            y = shape_y[i];
         end else begin
            x = pick_between(left, right);
            y = pick_between(bottom, top);
            case ($urandom_range(0, 5))
               0: x = clamp16(left - 1);
               1: x = clamp16(right + 1);
               2: y = clamp16(bottom - 1);
               3: y = clamp16(top + 1);
               4: x = left;
               default: y = top;
            endcase
         end
         push_item(pip_pkg::KIND_QUERY, 1'($urandom_range(0, 1)), x, y, 1'b0);
      end
   endtask

   task automatic fill_stimulus();
      int n, r;
      bit first;
      // no polygon, then one and two vertices
      push_item(pip_pkg::KIND_QUERY, 1'b1, 0, 0, 1'b0);
      push_item(pip_pkg::KIND_VERTEX, 1'b1, 0, 0, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 0, 0, 1'b0);
      push_item(pip_pkg::KIND_VERTEX, 1'b0, 10, 0, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 2, 2, 1'b0);
      // right triangle with a horizontal and a vertical edge
      push_item(pip_pkg::KIND_VERTEX, 1'b0, 0, 10, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 2, 2, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 0, 0, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 5, 0, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 5, 5, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 0, 5, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 6, 6, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 11, 0, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, -1, 5, 1'b0);
      // full coordinate range square, sent only once the block is drained
      push_item(pip_pkg::KIND_VERTEX, 1'b1, -32768, -32768, 1'b1);
      push_item(pip_pkg::KIND_VERTEX, 1'b0, 32767, -32768, 1'b0);
      push_item(pip_pkg::KIND_VERTEX, 1'b0, 32767, 32767, 1'b0);
      push_item(pip_pkg::KIND_VERTEX, 1'b0, -32768, 32767, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 0, 0, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, -32768, 0, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 32767, 32767, 1'b0);
      // repeated vertices
      push_item(pip_pkg::KIND_VERTEX, 1'b1, 5, 5, 1'b0);
      push_item(pip_pkg::KIND_VERTEX, 1'b0, 5, 5, 1'b0);
      push_item(pip_pkg::KIND_VERTEX, 1'b0, 5, 5, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 5, 5, 1'b0);
      push_item(pip_pkg::KIND_QUERY, 1'b0, 5, 6, 1'b0);
      first = 1'b1;
      while (pending_items.size() < TARGET_ITEMS) begin
         r = $urandom_range(0, 99);
         if (first) n = pip_pkg::MAX_VERTICES + 2;
         else if (r < 4) n = pick_between(1, 2);
         else if (r < 9) n = pick_between(pip_pkg::MAX_VERTICES - 4, pip_pkg::MAX_VERTICES + 4);
         else n = pick_between(pip_pkg::MIN_VERTICES, 12);
         build_polygon(n, !first && ($urandom_range(0, 29) == 0),
                       first || ($urandom_range(0, 99) >= 3));
         add_queries((n > 40) ? pick_between(2, 4) : pick_between(1, 8));
         first = 1'b0;
      end
      total_items = pending_items.size();
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin : drive_requests
      bit send;
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.kind        <= pip_pkg::KIND_VERTEX;
         req_bus.new_polygon <= 1'b0;
         req_bus.point_x     <= '0;
         req_bus.point_y     <= '0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (req_bus.valid) begin
            apply_transaction(pending_items.pop_front());
            accepted_count++;
         end
         send = (pending_items.size() != 0) && ($urandom_range(0, 99) >= idle_pct(1'b0));
         if (send && pending_items[0].hold_until_done && expected_relations.size() != 0)
            send = 1'b0;
         if (send) begin
            req_bus.valid       <= 1'b1;
            req_bus.kind        <= pending_items[0].kind;
            req_bus.new_polygon <= pending_items[0].new_polygon;
            req_bus.point_x     <= pending_items[0].x;
            req_bus.point_y     <= pending_items[0].y;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_responses
      pip_pkg::relation_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_relations.size() == 0) begin
               report_mismatch($sformatf("relation %0d with no query outstanding",
                                         rsp_bus.relation));
            end else begin
               want = expected_relations.pop_front();
               if (rsp_bus.relation !== want)
                  report_mismatch($sformatf("relation %0d, expected %s",
                                            rsp_bus.relation, want.name()));
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
      end
   end

   initial begin
      accepted_count = 0;
      mismatch_count = 0;
      poly_count     = 0;
      poly_overflow  = 1'b0;
      poly_box       = '0;
      reset          = 1'b1;
      fill_stimulus();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count < total_items || expected_relations.size() != 0)
         @(posedge clock);
      repeat (pip_pkg::MAX_VERTICES + 20) @(posedge clock);
      if (mismatch_count == 0)
         $display("point_in_polygon_test_tb: PASS");
      else
         $display("point_in_polygon_test_tb: FAIL");
      $finish;
   end

   initial begin
      #RUN_LIMIT;
      $display("point_in_polygon_test_tb: FAIL");
      $finish;
   end

endmodule
